// ===== sv/spq_pkg.sv =====
// Package with the shared types and codes of the sorted priority queue.
package spq_pkg;

  // Widths of the word fields.
  localparam int DataW  = 32;
  localparam int PrioW  = 8;
  localparam int CountW = 8;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [PrioW-1:0]        prio_t;
  typedef logic [CountW-1:0]       count_out_t;

  // Request codes carried by req_type.
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_t;

  // Command that travels from the control logic to the cells.
  typedef struct packed {
    cell_op_t op;
    data_t    data;
    prio_t    prio;
  } cell_cmd_t;

  // Data word returned on an empty dequeue.
  localparam data_t UnderflowData = '1;

endpackage

// ===== sv/spq_if.sv =====
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
  import spq_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  data_t data_in;
  prio_t prio_in;

  modport source (output valid, req_type, data_in, prio_in, input ready);
  modport sink (input valid, req_type, data_in, prio_in, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  data_t      data_out;
  count_out_t count_out;

  modport source (output valid, status, data_out, count_out, input ready);
  modport sink (input valid, status, data_out, count_out, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One cell of the queue chain: holds one entry and trades it with its neighbours.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic              occupied,
  input  logic              left_keep,
  input  spq_pkg::data_t    left_data,
  input  spq_pkg::prio_t    left_prio,
  input  spq_pkg::data_t    right_data,
  input  spq_pkg::prio_t    right_prio,
  output logic              keep,
  output spq_pkg::data_t    data,
  output spq_pkg::prio_t    prio
);
  import spq_pkg::*;

  data_t data_next;
  prio_t prio_next;

  // An occupied entry of equal or higher priority stays where it is on a push.
  assign keep = occupied && (prio >= cmd.prio);

  // Choose the entry this cell holds after the operation.
  always_comb begin
    data_next = data;
    prio_next = prio;
    unique case (cmd.op)
      OP_HOLD: begin
        data_next = data;
      end
      OP_PUSH: begin
        if (!keep) begin
          if (left_keep) begin
            data_next = cmd.data;
            prio_next = cmd.prio;
          end else begin
            data_next = left_data;
            prio_next = left_prio;
          end
        end
      end
      OP_POP: begin
        data_next = right_data;
        prio_next = right_prio;
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  // Entry storage; only cells below the count are ever read.
  always_ff @(posedge clk) begin
    data <= data_next;
    prio <= prio_next;
  end

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a chain of entry cells and its control.
//
//   Channel  Role  Word contents
//   req      sink  req_type, data_in, prio_in
//   rsp      src   status, data_out, count_out
//
// All cells compare the new priority against their own entry at once and
// shift in a single step, so one request is taken per cycle while the response
// is not stalled. The result sits in an output register and appears in the cycle
// after acceptance; a new request is taken while the last result is
// taken in the same cycle. Reset empties the queue at once, with no sweep.
// A stalled response holds off further requests.
module sorted_priority_queue_unit #(
  parameter int DEPTH = 128
) (
  input logic          clk,
  input logic          rst,
  spq_req_if.sink      req,
  spq_rsp_if.source    rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  logic          req_fire;
  cell_cmd_t     cmd;

  data_t         cell_data [DEPTH];
  prio_t         cell_prio [DEPTH];
  logic          cell_keep [DEPTH];
  logic          cell_occ  [DEPTH];

  status_t       status_next;
  data_t         data_out_next;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_fire = req.valid && req.ready;

  // Build the command for the chain and the result of this request.
  always_comb begin
    cmd.op        = OP_HOLD;
    cmd.data      = req.data_in;
    cmd.prio      = req.prio_in;
    count_next    = count;
    status_next   = ST_DONE;
    data_out_next = '0;
    if (req.req_type == REQ_ENQ) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else begin
        cmd.op     = req_fire ? OP_PUSH : OP_HOLD;
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        status_next   = ST_UNDERFLOW;
        data_out_next = UnderflowData;
      end else begin
        cmd.op        = req_fire ? OP_POP : OP_HOLD;
        count_next    = count - CW'(1);
        data_out_next = cell_data[0];
      end
    end
  end

  // The chain of cells, each wired to its neighbours.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  lk;
    data_t ld;
    prio_t lp;
    data_t rd;
    prio_t rp;

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign ld = cmd.data;
      assign lp = cmd.prio;
    end else begin : g_body
      assign lk = cell_keep[i-1];
      assign ld = cell_data[i-1];
      assign lp = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rd = cell_data[i];
      assign rp = cell_prio[i];
    end else begin : g_mid
      assign rd = cell_data[i+1];
      assign rp = cell_prio[i+1];
    end

    assign cell_occ[i] = (CW'(i) < count);

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (cell_occ[i]),
      .left_keep  (lk),
      .left_data  (ld),
      .left_prio  (lp),
      .right_data (rd),
      .right_prio (rp),
      .keep       (cell_keep[i]),
      .data       (cell_data[i]),
      .prio       (cell_prio[i])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_fire) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.status    <= status_next;
      rsp.data_out  <= data_out_next;
      rsp.count_out <= CountW'(count_next);
    end
  end

  // The count never runs past the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // An accepted enqueue into a queue with room adds exactly one entry.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.req_type == REQ_ENQ) && !full |=> count == $past(count) + CW'(1))
    else $error("enqueue did not add one entry");

  // An empty dequeue reports all ones and an empty queue.
  a_underflow: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == ST_UNDERFLOW) |-> (rsp.count_out == '0) &&
    (rsp.data_out == UnderflowData))
    else $error("bad underflow result");

  // The two front entries stay in priority order.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cell_prio[1] <= cell_prio[0]))
    else $error("head entries out of order");

endmodule

// ===== tb/spq_order_checker.sv =====
// Checker that predicts every response of the sorted priority queue and compares it.
module spq_order_checker #(
  parameter int Depth = 128
) (
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct packed {
    status_t    status;
    data_t      data;
    count_out_t count;
  } reply_t;

  // Own copy of the queue contents, kept sorted from highest priority down.
  data_t  held_data [Depth];
  prio_t  held_prio [Depth];
  int     fill;
  reply_t due_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fill        = 0;
  end

  // Applies one request to the local copy and returns the reply it should give.
  function automatic reply_t serve_request(req_t kind, data_t word, prio_t level);
    reply_t r;
    int     pos;
    r.status = ST_DONE;
    r.data   = '0;
    if (kind == REQ_ENQ) begin
      if (fill >= Depth) begin
        r.status = ST_OVERFLOW;
      end else begin
        // Step past every entry of lower priority so that ties keep arrival order.
        pos = fill;
        while (pos > 0 && held_prio[pos-1] < level) begin
          held_data[pos] = held_data[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_data[pos] = word;
        held_prio[pos] = level;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = ST_UNDERFLOW;
      r.data   = UnderflowData;
    end else begin
      r.data = held_data[0];
      for (int k = 1; k < fill; k++) begin
        held_data[k-1] = held_data[k];
        held_prio[k-1] = held_prio[k];
      end
      fill--;
    end
    r.count = fill[CountW-1:0];
    return r;
  endfunction

  // Compare each response word with the oldest prediction, then queue new ones.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      fill = 0;
      due_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_replies.size() == 0) begin
          $display("%0t: response word with no request waiting (status %0d, data %h, count %0d)",
                   $time, rsp.status, rsp.data_out, rsp.count_out);
          mismatches++;
        end else begin
          want = due_replies.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, rsp.status);
            mismatches++;
          end
          if (rsp.data_out !== want.data) begin
            $display("%0t: data_out expected %h, got %h", $time, want.data, rsp.data_out);
            mismatches++;
          end
          if (rsp.count_out !== want.count) begin
            $display("%0t: count_out expected %0d, got %0d", $time, want.count, rsp.count_out);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready) begin
        due_replies.insert(due_replies.size(),
                           serve_request(req_t'(req.req_type), req.data_in, req.prio_in));
      end
    end
    outstanding = due_replies.size();
  end

endmodule

// ===== tb/sorted_priority_queue_unit_tb.sv =====
// Testbench top of the sorted priority queue: clock, reset, stimulus and verdict.
module sorted_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int QDepth     = 128;
  localparam int ItemTarget = 750;

  logic clk;
  logic rst;
  logic req_taken;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   occupancy;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue_unit #(.DEPTH(QDepth)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  spq_order_checker #(.Depth(QDepth)) order_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_bus),
    .rsp         (rsp_bus),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Registered acceptance flag, read by the sender at the next falling edge.
  always @(posedge clk) begin
    req_taken <= req_bus.valid && req_bus.ready;
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // Response back-pressure: runs of acceptance broken by short and long stalls.
  initial begin
    int run;
    int stall;
    rsp_bus.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        run   = $urandom_range(100, 300);
        stall = 1;
      end else begin
        run   = $urandom_range(1, 12);
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      rsp_bus.ready <= 1'b1;
      repeat (run) @(negedge clk);
      rsp_bus.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic data_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return data_t'($urandom);
    endcase
  endfunction

  // A narrow spread of priorities produces many ties.
  function automatic prio_t rand_level(bit narrow);
    if (narrow) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return 8'h80;
        default: return 8'h7F;
      endcase
    end
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return prio_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Presents one request word and returns at the falling edge after it is taken.
  task automatic send_word(req_t kind, data_t word, prio_t level, int gap);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.data_in  <= word;
    req_bus.prio_in  <= level;
    do @(negedge clk); while (!req_taken);
    items_sent++;
    if (kind == REQ_ENQ && occupancy < QDepth) occupancy++;
    if (kind == REQ_DEQ && occupancy > 0) occupancy--;
  endtask

  task automatic pause_until_drained();
    req_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Fill the queue past full, then empty it past empty.
  task automatic fill_and_drain(bit quiet, bit narrow);
    int n;
    n = QDepth - occupancy + $urandom_range(1, 4);
    repeat (n) send_word(REQ_ENQ, rand_word(), rand_level(narrow), pick_gap(quiet));
    if ($urandom_range(0, 1) == 0) pause_until_drained();
    n = occupancy + $urandom_range(1, 3);
    repeat (n) send_word(REQ_DEQ, rand_word(), rand_level(0), pick_gap(quiet));
  endtask

  // Interleaved enqueues and dequeues with a random bias.
  task automatic mixed_run(bit quiet);
    int   len;
    int   enq_pct;
    bit   narrow;
    len     = $urandom_range(20, 60);
    enq_pct = $urandom_range(35, 75);
    narrow  = $urandom_range(0, 1);
    repeat (len) begin
      if ($urandom_range(0, 99) < enq_pct) begin
        send_word(REQ_ENQ, rand_word(), rand_level(narrow), pick_gap(quiet));
      end else begin
        send_word(REQ_DEQ, rand_word(), rand_level(0), pick_gap(quiet));
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    bit quiet;
    rst              = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_ENQ;
    req_bus.data_in  = '0;
    req_bus.prio_in  = '0;
    items_sent       = 0;
    occupancy        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty dequeue, field extremes, ties at the head and in the middle.
    send_word(REQ_DEQ, '1, 8'hFF, 0);
    send_word(REQ_ENQ, 32'h7FFF_FFFF, 8'h00, 0);
    send_word(REQ_ENQ, 32'h8000_0000, 8'hFF, 0);
    send_word(REQ_ENQ, '1, 8'h80, 0);
    send_word(REQ_ENQ, '0, 8'h80, 0);
    send_word(REQ_ENQ, 32'h5555_5555, 8'h80, 0);
    send_word(REQ_ENQ, 32'hAAAA_AAAA, 8'hFF, 0);
    send_word(REQ_ENQ, 32'h0000_0001, 8'h00, 0);
    for (int k = 0; k < 8; k++) begin
      send_word(REQ_DEQ, (k % 2) ? '1 : '0, (k % 2) ? 8'hFF : 8'h00, 0);
    end
    pause_until_drained();

    // Random: one full fill and drain first, then a mix of phases.
    fill_and_drain(0, 1);
    while (items_sent < ItemTarget) begin
      quiet = ($urandom_range(0, 3) == 0);
      // A fill and drain is only started while it still fits within the item budget.
      if (($urandom_range(0, 5) == 0) && (items_sent + 2 * QDepth + 8 <= ItemTarget)) begin
        fill_and_drain(quiet, $urandom_range(0, 1));
      end else begin
        mixed_run(quiet);
      end
      if ($urandom_range(0, 3) == 0) pause_until_drained();
    end

    req_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
